### src/fcce_pkg.sv
package fcce_pkg;

  // widths fixed by the field definitions
  localparam int unsigned NW = 13;

  // command codes
  localparam logic [2:0] CMD_WRITE  = 3'd0;
  localparam logic [2:0] CMD_READ   = 3'd1;
  localparam logic [2:0] CMD_ALLOC  = 3'd2;
  localparam logic [2:0] CMD_EXTEND = 3'd3;
  localparam logic [2:0] CMD_FREE   = 3'd4;
  localparam logic [2:0] CMD_COUNT  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  localparam logic [15:0]   FAT_EOC       = 16'hFFFF;
  localparam logic [15:0]   FAT_FREE      = 16'h0000;
  localparam logic [15:0]   FIRST_CLUSTER = 16'd2;
  localparam logic [NW-1:0] TE_RESET      = 13'd2304;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [11:0] index;
    logic [15:0] value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] data;
  } out_req_t;

  // table write selection
  typedef enum logic [2:0] {
    MOP_NONE,
    MOP_WR_IN,
    MOP_WR_EOC,
    MOP_WR_LINK,
    MOP_CLR_CUR
  } mop_t;

  // table read address selection
  typedef enum logic [1:0] {
    RA_IDX,
    RA_FIRST,
    RA_SCAN_NEXT,
    RA_NEXT
  } rsel_t;

  // result data selection
  typedef enum logic [1:0] {
    DS_ZERO,
    DS_RDATA,
    DS_SCAN,
    DS_CNT1
  } dsel_t;

  typedef struct packed {
    logic       ld_in;
    mop_t       mop;
    rsel_t      rsel;
    logic       scan_init;
    logic       scan_inc;
    logic       walk_init;
    logic       walk_step;
    logic       res_set;
    logic [1:0] res_status;
    dsel_t      res_dsel;
    logic       out_load;
  } ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       idx_ok;
    logic       chain_idx_ok;
    logic       n_small;
    logic       rd_free;
    logic       rd_eoc;
    logic       scan_last;
    logic       next_bad;
  } sts_t;

endpackage

### src/fcce_ctrl.sv
module fcce_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  fcce_pkg::sts_t sts,
  output fcce_pkg::ctl_t ctl
);
  import fcce_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_RD,
    S_EXT,
    S_SCAN,
    S_LINK,
    S_WALK,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    ctl.ld_in      = 1'b0;
    ctl.mop        = MOP_NONE;
    ctl.rsel       = RA_IDX;
    ctl.scan_init  = 1'b0;
    ctl.scan_inc   = 1'b0;
    ctl.walk_init  = 1'b0;
    ctl.walk_step  = 1'b0;
    ctl.res_set    = 1'b0;
    ctl.res_status = ST_OK;
    ctl.res_dsel   = DS_ZERO;
    ctl.out_load   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.ld_in = 1'b1;
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        state_nxt = S_FIN;
        ctl.res_set = 1'b1;
        ctl.res_status = ST_BAD;
        case (sts.cmd)
          CMD_WRITE: begin
            if (sts.idx_ok) begin
              ctl.mop = MOP_WR_IN;
              ctl.res_status = ST_OK;
            end
          end
          CMD_READ: begin
            if (sts.idx_ok) begin
              ctl.res_set = 1'b0;
              ctl.rsel = RA_IDX;
              state_nxt = S_RD;
            end
          end
          CMD_ALLOC: begin
            if (sts.n_small) begin
              ctl.res_status = ST_FULL;
            end else begin
              ctl.res_set = 1'b0;
              ctl.rsel = RA_FIRST;
              ctl.scan_init = 1'b1;
              state_nxt = S_SCAN;
            end
          end
          CMD_EXTEND: begin
            if (sts.chain_idx_ok) begin
              ctl.res_set = 1'b0;
              ctl.rsel = RA_IDX;
              state_nxt = S_EXT;
            end
          end
          CMD_FREE, CMD_COUNT: begin
            if (sts.chain_idx_ok) begin
              ctl.res_set = 1'b0;
              ctl.rsel = RA_IDX;
              ctl.walk_init = 1'b1;
              state_nxt = S_WALK;
            end
          end
          default: begin
            ctl.res_status = ST_BAD;
          end
        endcase
      end

      S_RD: begin
        ctl.res_set = 1'b1;
        ctl.res_status = ST_OK;
        ctl.res_dsel = DS_RDATA;
        state_nxt = S_FIN;
      end

      // tail check before the free search
      S_EXT: begin
        if (!sts.rd_eoc) begin
          ctl.res_set = 1'b1;
          ctl.res_status = ST_BAD;
          state_nxt = S_FIN;
        end else if (sts.n_small) begin
          ctl.res_set = 1'b1;
          ctl.res_status = ST_FULL;
          state_nxt = S_FIN;
        end else begin
          ctl.rsel = RA_FIRST;
          ctl.scan_init = 1'b1;
          state_nxt = S_SCAN;
        end
      end

      // one entry a cycle, read pipelined one ahead
      S_SCAN: begin
        if (sts.rd_free) begin
          ctl.mop = MOP_WR_EOC;
          if (sts.cmd == CMD_EXTEND) begin
            state_nxt = S_LINK;
          end else begin
            ctl.res_set = 1'b1;
            ctl.res_status = ST_OK;
            ctl.res_dsel = DS_SCAN;
            state_nxt = S_FIN;
          end
        end else if (sts.scan_last) begin
          ctl.res_set = 1'b1;
          ctl.res_status = ST_FULL;
          state_nxt = S_FIN;
        end else begin
          ctl.rsel = RA_SCAN_NEXT;
          ctl.scan_inc = 1'b1;
        end
      end

      S_LINK: begin
        ctl.mop = MOP_WR_LINK;
        ctl.res_set = 1'b1;
        ctl.res_status = ST_OK;
        ctl.res_dsel = DS_SCAN;
        state_nxt = S_FIN;
      end

      S_WALK: begin
        if (sts.cmd == CMD_FREE) begin
          ctl.mop = MOP_CLR_CUR;
        end
        if (sts.rd_eoc) begin
          ctl.res_set = 1'b1;
          ctl.res_status = ST_OK;
          ctl.res_dsel = (sts.cmd == CMD_COUNT) ? DS_CNT1 : DS_ZERO;
          state_nxt = S_FIN;
        end else if (sts.next_bad) begin
          ctl.res_set = 1'b1;
          ctl.res_status = ST_BAD;
          state_nxt = S_FIN;
        end else begin
          ctl.rsel = RA_NEXT;
          ctl.walk_step = 1'b1;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          ctl.out_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### src/fcce_dp.sv
module fcce_dp #(
  parameter int unsigned MAX_ENTRIES = 4096
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  fcce_pkg::in_req_t        in_req,
  input  logic                     cfg_wr_en,
  input  logic [fcce_pkg::NW-1:0]  cfg_wr_data,
  input  fcce_pkg::ctl_t           ctl,
  output fcce_pkg::sts_t           sts,
  output fcce_pkg::out_req_t       out_req
);
  import fcce_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_ENTRIES);
  localparam logic [16:0] MAX_W = 17'(MAX_ENTRIES);

  logic [15:0]   mem [MAX_ENTRIES];

  logic [NW-1:0] te_r;
  logic [2:0]    cmd_r;
  logic [11:0]   idx_r;
  logic [15:0]   val_r;
  logic [NW-1:0] scan_r;
  logic [15:0]   cur_r;
  logic [NW-1:0] cnt_r;
  logic [1:0]    res_status_r;
  logic [15:0]   res_data_r;
  out_req_t      out_req_r;
  logic [15:0]   mem_q_r;
  logic          byp_r;
  logic [15:0]   byp_data_r;

  logic [NW-1:0] n;
  logic [NW-1:0] scan_inc;
  logic [NW-1:0] cnt_inc;
  logic [15:0]   rdata;
  logic          we;
  logic [15:0]   waddr16;
  logic [15:0]   wdata;
  logic [15:0]   raddr16;
  logic [15:0]   res_data;

  // table size in use, capped at the storage depth
  assign n = ({4'b0, te_r} > MAX_W) ? MAX_W[NW-1:0] : te_r;

  assign scan_inc = scan_r + 13'd1;
  assign cnt_inc  = cnt_r + 13'd1;
  // write-to-read forwarding for same-cycle clear and reread
  assign rdata    = byp_r ? byp_data_r : mem_q_r;

  always_comb begin
    we      = 1'b1;
    waddr16 = {4'b0, idx_r};
    wdata   = val_r;
    case (ctl.mop)
      MOP_WR_IN: begin
        waddr16 = {4'b0, idx_r};
        wdata   = val_r;
      end
      MOP_WR_EOC: begin
        waddr16 = {3'b0, scan_r};
        wdata   = FAT_EOC;
      end
      MOP_WR_LINK: begin
        waddr16 = {4'b0, idx_r};
        wdata   = {3'b0, scan_r};
      end
      MOP_CLR_CUR: begin
        waddr16 = cur_r;
        wdata   = FAT_FREE;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (ctl.rsel)
      RA_IDX:       raddr16 = {4'b0, idx_r};
      RA_FIRST:     raddr16 = FIRST_CLUSTER;
      RA_SCAN_NEXT: raddr16 = {3'b0, scan_inc};
      RA_NEXT:      raddr16 = rdata;
      default:      raddr16 = {4'b0, idx_r};
    endcase
  end

  always_comb begin
    case (ctl.res_dsel)
      DS_RDATA: res_data = rdata;
      DS_SCAN:  res_data = {3'b0, scan_r};
      DS_CNT1:  res_data = {3'b0, cnt_inc};
      default:  res_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr16[AW-1:0]] <= wdata;
    end
    mem_q_r    <= mem[raddr16[AW-1:0]];
    byp_r      <= we && (waddr16 == raddr16);
    byp_data_r <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      te_r <= TE_RESET;
    end else if (cfg_wr_en) begin
      te_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_in) begin
      cmd_r <= in_req.cmd;
      idx_r <= in_req.index;
      val_r <= in_req.value;
    end
    if (ctl.scan_init) begin
      scan_r <= FIRST_CLUSTER[NW-1:0];
    end else if (ctl.scan_inc) begin
      scan_r <= scan_inc;
    end
    if (ctl.walk_init) begin
      cur_r <= {4'b0, idx_r};
      cnt_r <= '0;
    end else if (ctl.walk_step) begin
      cur_r <= rdata;
      cnt_r <= cnt_inc;
    end
    if (ctl.res_set) begin
      res_status_r <= ctl.res_status;
      res_data_r   <= res_data;
    end
    if (ctl.out_load) begin
      out_req_r.status <= res_status_r;
      out_req_r.data   <= res_data_r;
    end
  end

  assign sts.cmd          = cmd_r;
  assign sts.idx_ok       = ({1'b0, idx_r} < n);
  assign sts.chain_idx_ok = ({4'b0, idx_r} >= FIRST_CLUSTER) && ({1'b0, idx_r} < n);
  assign sts.n_small      = (n <= FIRST_CLUSTER[NW-1:0]);
  assign sts.rd_free      = (rdata == FAT_FREE);
  assign sts.rd_eoc       = (rdata == FAT_EOC);
  assign sts.scan_last    = (scan_inc >= n);
  assign sts.next_bad     = (rdata < FIRST_CLUSTER) || (rdata >= {3'b0, n}) || (cnt_inc >= n);

  assign out_req = out_req_r;

endmodule

### src/fat_cluster_chain_engine_unit.sv
// channel   direction  handshake              payload
// in_       request    in_valid / in_ready    fcce_pkg::in_req_t   (cmd, index, value)
// out_      result     out_valid / out_ready  fcce_pkg::out_req_t  (status, data)
// cfg_      config     cfg_wr_en, no wait     cfg_wr_data          (table_entries)
//
// allocate and extend search for a free entry starting at cluster 2; free and count walk the chain
// the one-read-per-cycle table port sets the pace of free searches and chain walks
// reset: synchronous active-low rst_n clears control and loads table_entries with 2304;
//   table contents are not cleared and stay undefined until written
// stalls: a finished result waits in the output register while the next request is taken

module fat_cluster_chain_engine_unit #(
  parameter int unsigned MAX_ENTRIES = 4096
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  fcce_pkg::in_req_t        in_req,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output fcce_pkg::out_req_t       out_req,
  // table_entries register
  input  logic                     cfg_wr_en,
  input  logic [fcce_pkg::NW-1:0]  cfg_wr_data
);
  import fcce_pkg::*;

  ctl_t ctl;   // controller to datapath commands
  sts_t sts;   // datapath compare results back to controller

  // sequencer: dispatch, free search, chain walk, result hand-off
  fcce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // fat storage, walk and search registers, size register, output register
  fcce_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_req),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ctl         (ctl),
    .sts         (sts),
    .out_req     (out_req)
  );

endmodule
